/* hw/rtl/utp_pkg.sv */
// shared types, constants and helper functions of the timestamp parser
package utp_pkg;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TZ      = 2'd2;

  // field widths
  localparam int YEAR_W = 14;
  localparam int FIELD_W = 7;
  localparam int FRAC_W = 30;
  localparam int FCNT_W = 4;
  localparam int SECS_W = 39;

  // nanosecond resolution in decimal digits
  localparam int NS_DIGITS = 9;
  localparam int FRAC_DIGITS_DEFAULT = 9;

  // depth of the queue between parser and converter
  localparam int UTP_QUEUE_DEPTH = 2;

  // days from 0000-03-01 (shifted by one 400-year era) to 1970-01-01, plus one for day 1
  localparam logic [23:0] DAYS_BIAS = 24'd865566;

  // one parsed timestamp handed to the converter
  typedef struct packed {
    logic [1:0]         status;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FRAC_W-1:0]  frac;
    logic [FCNT_W-1:0]  frac_count;
  } utp_job_t;

  // floor(x / 25) for x below 2602, by reciprocal multiply
  function automatic logic [6:0] div25(input logic [11:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'd5243;
    return prod[23:17];
  endfunction

  // days from 1 March to the first of month m, year counted from March
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/utp_front.sv */
// byte-wise parser: checks the template and gathers the date and time fields
module utp_front import utp_pkg::*; #(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic [7:0] char_byte,
  input  logic     last_byte,
  output logic     job_valid,
  output utp_job_t job
);

  // fraction digits that still matter at nanosecond resolution
  localparam int KEEP = (FRAC_DIGITS < NS_DIGITS) ? FRAC_DIGITS : NS_DIGITS;

  // parse positions
  localparam logic [4:0] PH_LEAD      = 5'd0;
  localparam logic [4:0] POS_DASH1    = 5'd4;
  localparam logic [4:0] POS_MONTH    = 5'd5;
  localparam logic [4:0] POS_DASH2    = 5'd7;
  localparam logic [4:0] POS_DAY      = 5'd8;
  localparam logic [4:0] POS_T        = 5'd10;
  localparam logic [4:0] POS_HOUR     = 5'd11;
  localparam logic [4:0] POS_COLON1   = 5'd13;
  localparam logic [4:0] POS_MINUTE   = 5'd14;
  localparam logic [4:0] POS_COLON2   = 5'd16;
  localparam logic [4:0] POS_SECOND   = 5'd17;
  localparam logic [4:0] POS_LAST     = 5'd18;
  localparam logic [4:0] PH_AFTER_SEC = 5'd19;
  localparam logic [4:0] PH_FRACTION  = 5'd20;
  localparam logic [4:0] PH_AFTER_Z   = 5'd21;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_Z     = 8'h5A;

  logic [4:0]         phase, phase_next;
  logic [YEAR_W-1:0]  year, year_next;
  logic [FIELD_W-1:0] month, month_next;
  logic [FIELD_W-1:0] day, day_next;
  logic [FIELD_W-1:0] hour, hour_next;
  logic [FIELD_W-1:0] minute, minute_next;
  logic [FIELD_W-1:0] second, second_next;
  logic [FRAC_W-1:0]  frac, frac_next;
  logic [FCNT_W-1:0]  fcount, fcount_next;
  logic [1:0]         err, err_next;
  logic [1:0]         final_status;
  logic               is_ws, is_digit, is_sep;
  logic [7:0]         want;
  logic [3:0]         digit;

  // character classes
  assign is_ws    = (char_byte == CH_SPACE) || (char_byte == CH_LF) ||
                    (char_byte == CH_CR) || (char_byte == CH_TAB);
  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign digit    = char_byte[3:0];

  // separator expected at this template position
  always_comb begin
    is_sep = 1'b1;
    want   = CH_DASH;
    case (phase)
      POS_DASH1, POS_DASH2:   want = CH_DASH;
      POS_T:                  want = CH_T;
      POS_COLON1, POS_COLON2: want = CH_COLON;
      default:                is_sep = 1'b0;
    endcase
  end

  // next parse state for this byte
  always_comb begin
    phase_next  = phase;
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    frac_next   = frac;
    fcount_next = fcount;
    err_next    = err;
    if (err == ST_OK) begin
      if ((phase == PH_LEAD) && is_ws) begin
        phase_next = phase;
      end else if (phase <= POS_LAST) begin
        if (is_sep) begin
          if (char_byte != want) err_next = ST_INVALID;
          else phase_next = phase + 5'd1;
        end else if (!is_digit) begin
          err_next = ST_INVALID;
        end else begin
          phase_next = phase + 5'd1;
          if (phase < POS_DASH1) year_next = YEAR_W'(year * 14'd10) + YEAR_W'(digit);
          else if (phase < POS_DAY) month_next = FIELD_W'(month * 7'd10) + FIELD_W'(digit);
          else if (phase < POS_HOUR) day_next = FIELD_W'(day * 7'd10) + FIELD_W'(digit);
          else if (phase < POS_MINUTE) hour_next = FIELD_W'(hour * 7'd10) + FIELD_W'(digit);
          else if (phase < POS_SECOND)
            minute_next = FIELD_W'(minute * 7'd10) + FIELD_W'(digit);
          else second_next = FIELD_W'(second * 7'd10) + FIELD_W'(digit);
        end
      end else if (phase == PH_AFTER_SEC) begin
        if (char_byte == CH_DOT) phase_next = PH_FRACTION;
        else if (char_byte == CH_Z) phase_next = PH_AFTER_Z;
        else err_next = ST_TZ;
      end else if (phase == PH_FRACTION) begin
        if (is_digit) begin
          if (fcount < FCNT_W'(KEEP)) begin
            frac_next   = FRAC_W'(frac * 30'd10) + FRAC_W'(digit);
            fcount_next = fcount + 4'd1;
          end
        end else if (char_byte == CH_Z) begin
          phase_next = PH_AFTER_Z;
        end else begin
          err_next = ST_TZ;
        end
      end else begin
        if (!is_ws) err_next = ST_INVALID;
      end
    end
  end

  // status reported when the text ends here
  always_comb begin
    if (err_next != ST_OK) final_status = err_next;
    else if (phase_next == PH_AFTER_Z) final_status = ST_OK;
    else if ((phase_next == PH_AFTER_SEC) || (phase_next == PH_FRACTION)) final_status = ST_TZ;
    else final_status = ST_INVALID;
  end

  // job handed to the queue on the final byte
  assign job_valid       = accept && last_byte;
  assign job.status      = final_status;
  assign job.year        = year_next;
  assign job.month       = month_next;
  assign job.day         = day_next;
  assign job.hour        = hour_next;
  assign job.minute      = minute_next;
  assign job.second      = second_next;
  assign job.frac        = frac_next;
  assign job.frac_count  = fcount_next;

  // parse state registers, cleared after each text
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase  <= PH_LEAD;
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      frac   <= '0;
      fcount <= '0;
      err    <= ST_OK;
    end else if (accept) begin
      phase  <= phase_next;
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      frac   <= frac_next;
      fcount <= fcount_next;
      err    <= err_next;
    end
  end

  // a finished text leaves the parser back at the start
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (phase == PH_LEAD && err == ST_OK && fcount == '0))
    else $error("parser not cleared after final byte");

endmodule

/* hw/rtl/utp_queue.sv */
// short job queue between the parser and the seconds converter
module utp_queue import utp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  utp_job_t wr_data,
  output logic     full,
  input  logic     pop,
  output utp_job_t rd_data,
  output logic     empty
);

  localparam int DEPTH = UTP_QUEUE_DEPTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  utp_job_t        mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* hw/rtl/utp_back.sv */
// seconds converter: month carry, calendar arithmetic and fraction scaling
module utp_back import utp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_empty,
  input  utp_job_t           job,
  output logic               job_pop,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [SECS_W-1:0] out_secs,
  output logic [FRAC_W-1:0]  out_ns,
  input  logic               out_pop
);

  typedef enum logic [2:0] {
    B_IDLE, B_NORM, B_DAYS, B_SUM_DAYS, B_SECS, B_TOTAL, B_EMIT
  } back_state_t;

  back_state_t        st;
  logic [1:0]         status;
  logic signed [14:0] y;
  logic [FIELD_W-1:0] m;
  logic [FIELD_W-1:0] day, hr, mi, se;
  logic [FRAC_W-1:0]  frac;
  logic [FCNT_W-1:0]  fcnt;
  logic [22:0]        d365;
  logic [11:0]        q4;
  logic [6:0]         c100, c400;
  logic [8:0]         doy;
  logic [18:0]        hs;
  logic [12:0]        ms;
  logic signed [23:0] days;
  logic signed [39:0] ds;
  logic signed [39:0] secs;
  logic signed [14:0] yy_w;
  logic [13:0]        yy;
  logic               month_ok, frac_done;

  assign job_pop   = (st == B_IDLE) && !job_empty;
  assign month_ok  = (m >= 7'd1) && (m <= 7'd12);
  assign frac_done = (fcnt == FCNT_W'(NS_DIGITS));

  // year counted from March, shifted by one era to stay positive
  assign yy_w = y + 15'sd400 - ((m <= 7'd2) ? 15'sd1 : 15'sd0);
  assign yy   = yy_w[13:0];

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_pop && (st != B_EMIT)) out_valid <= 1'b0;
      unique case (st)
        B_IDLE: begin
          if (!job_empty) begin
            status <= job.status;
            y      <= signed'(15'(job.year));
            m      <= job.month;
            day    <= job.day;
            hr     <= job.hour;
            mi     <= job.minute;
            se     <= job.second;
            if (job.status == ST_OK) begin
              frac <= job.frac;
              fcnt <= job.frac_count;
              st   <= B_NORM;
            end else begin
              frac <= '0;
              fcnt <= FCNT_W'(NS_DIGITS);
              secs <= '0;
              st   <= B_EMIT;
            end
          end
        end
        // carry month into year, scale fraction to nanoseconds
        B_NORM: begin
          if (m == 7'd0) begin
            m <= 7'd12;
            y <= y - 15'sd1;
          end else if (m > 7'd12) begin
            m <= m - 7'd12;
            y <= y + 15'sd1;
          end
          if (!frac_done) begin
            frac <= FRAC_W'(frac * 30'd10);
            fcnt <= fcnt + 4'd1;
          end
          if (month_ok && frac_done) st <= B_DAYS;
        end
        // partial products of the day count and of the hour and minute seconds
        B_DAYS: begin
          d365 <= 23'(yy) * 23'd365;
          q4   <= yy[13:2];
          c100 <= div25(yy[13:2]);
          c400 <= div25({2'b00, yy[13:4]});
          doy  <= month_offset(m[3:0]);
          hs   <= 19'(hr) * 19'd3600;
          ms   <= 13'(mi) * 13'd60;
          st   <= B_SUM_DAYS;
        end
        B_SUM_DAYS: begin
          days <= signed'(24'(d365) + 24'(q4) - 24'(c100) + 24'(c400) + 24'(doy) +
                          24'(day) - DAYS_BIAS);
          st   <= B_SECS;
        end
        B_SECS: begin
          ds <= 40'(days) * 40'sd86400;
          st <= B_TOTAL;
        end
        B_TOTAL: begin
          secs <= signed'(ds + 40'(hs) + 40'(ms) + 40'(se));
          st   <= B_EMIT;
        end
        // a waiting result is either still held or leaves this cycle
        B_EMIT: begin
          if (!out_valid || out_pop) begin
            out_valid  <= 1'b1;
            out_status <= status;
            out_secs   <= secs[SECS_W-1:0];
            out_ns     <= frac;
            st         <= B_IDLE;
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  a_month_norm: assert property (@(posedge clk) disable iff (rst)
    (st == B_DAYS) |-> (m >= 7'd1 && m <= 7'd12 && fcnt == FCNT_W'(NS_DIGITS)))
    else $error("calendar step entered before normalising");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_secs == '0 && out_ns == '0))
    else $error("failed request carries a non-zero time");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (st == B_NORM || st == B_EMIT))
    else $error("job taken without starting conversion");

endmodule

/* hw/rtl/utc_timestamp_parser.sv */
// top level of the UTC timestamp parser: parser, job queue and seconds converter
//
//   channel   direction  handshake            payload
//   text      in         push / full          char_byte, last_byte
//   result    out        pop / empty          status, epoch_seconds, fraction_ns
//
// the parser takes one text byte per cycle while full is low; full rises only
// when both queue entries hold finished texts the converter has not started.
// a failed parse goes from the converter's idle state straight to its result register;
// a good one first runs the month carry and fraction scaling loop, then the calendar steps.
// synchronous reset clears the parser, queue and converter; a waiting result
// holds on its ports until popped, while the parser keeps taking bytes.
module utc_timestamp_parser import utp_pkg::*; #(
  parameter int FRAC_DIGITS = FRAC_DIGITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               char_byte,
  input  logic                     last_byte,
  input  logic                     push,
  output logic                     full,
  output logic [1:0]               status,
  output logic signed [SECS_W-1:0] epoch_seconds,
  output logic [FRAC_W-1:0]        fraction_ns,
  output logic                     empty,
  input  logic                     pop
);

  utp_job_t front_job, queue_job;
  logic     front_valid, queue_empty, queue_pop, accept, out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  // byte parser
  utp_front #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_byte (char_byte),
    .last_byte (last_byte),
    .job_valid (front_valid),
    .job       (front_job)
  );

  // decoupling queue
  utp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (front_valid),
    .wr_data (front_job),
    .full    (full),
    .pop     (queue_pop),
    .rd_data (queue_job),
    .empty   (queue_empty)
  );

  // seconds converter with result register
  utp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_empty  (queue_empty),
    .job        (queue_job),
    .job_pop    (queue_pop),
    .out_valid  (out_valid),
    .out_status (status),
    .out_secs   (epoch_seconds),
    .out_ns     (fraction_ns),
    .out_pop    (pop)
  );

endmodule
